/* src/ordered_typed_set_table_defines.svh */
// ---------------------------------------------------------------------------
// ordered_typed_set_table assertion macros
// Concurrent check forms used by the checker file ots_checker.
// ---------------------------------------------------------------------------
`ifndef ORDERED_TYPED_SET_TABLE_DEFINES_SVH
`define ORDERED_TYPED_SET_TABLE_DEFINES_SVH

// same-cycle implication
`define OTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ordered_typed_set_table: check failed");

// next-cycle implication
`define OTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ordered_typed_set_table: check failed");

`endif

/* src/ots_pkg.sv */
// ---------------------------------------------------------------------------
// ots_pkg
// Field widths, operation and status codes for the ordered typed set table.
// ---------------------------------------------------------------------------
package ots_pkg;

	localparam int OP_W    = 2;
	localparam int TAG_W   = 4;
	localparam int VAL_W   = 64;
	localparam int POS_W   = 6;
	localparam int STAT_W  = 3;
	localparam int CNT_O_W = 7;
	localparam int KEY_W   = TAG_W + VAL_W;

	localparam int DEF_CAPACITY = 64;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_DEL    = 2'd1,
		OP_MEMBER = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_MISS  = 3'd2,
		ST_FULL  = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

endpackage

/* src/ots_cmd_if.sv */
// ---------------------------------------------------------------------------
// ots_cmd_if
// Command channel: operation, key and position, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ots_cmd_if;
	import ots_pkg::*;

	logic               valid;
	logic               ready;
	op_t                op;
	logic [TAG_W-1:0]   key_type;
	logic [VAL_W-1:0]   key_value;
	logic [POS_W-1:0]   position;

	modport source (output valid, op, key_type, key_value, position, input ready);
	modport sink   (input valid, op, key_type, key_value, position, output ready);
endinterface

/* src/ots_rsp_if.sv */
// ---------------------------------------------------------------------------
// ots_rsp_if
// Response channel: status, membership, count and read entry.
// ---------------------------------------------------------------------------
interface ots_rsp_if;
	import ots_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic               found;
	logic [CNT_O_W-1:0] entry_count;
	logic [TAG_W-1:0]   read_type;
	logic [VAL_W-1:0]   read_value;

	modport source (output valid, status, found, entry_count, read_type, read_value,
		input ready);
	modport sink   (input valid, status, found, entry_count, read_type, read_value,
		output ready);
endinterface

/* src/ots_ram.sv */
// ---------------------------------------------------------------------------
// ots_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ots_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/ordered_typed_set_table.sv */
// ---------------------------------------------------------------------------
// ordered_typed_set_table
// Bounded insertion-ordered set of typed 64-bit keys held in one RAM.
//
//  channel | dir | payload
//  cmd     | in  | op, key_type, key_value, position
//  rsp     | out | status, found, entry_count, read_type, read_value
//
// Read: after accept, S_RD issues the RAM read, S_RDW takes the word and S_FIN
// loads the result register; a position past the end goes from S_RD straight
// to S_FIN. Add, delete and member scan the RAM one entry a cycle up to the
// first match or the count. Delete then copies each later entry down one
// place, one a cycle. Only one word is in work at a time; cmd is taken again
// once the result is registered, and the result waits there while rsp
// stalls. No clearing pass after reset.
// ---------------------------------------------------------------------------
module ordered_typed_set_table #(
	parameter int CAPACITY = ots_pkg::DEF_CAPACITY
) (
	input  logic     clk,
	input  logic     arst_n,
	ots_cmd_if.sink  cmd,
	ots_rsp_if.source rsp
);
	import ots_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RD    = 6'b000010,
		S_RDW   = 6'b000100,
		S_SCAN  = 6'b001000,
		S_SHIFT = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic               pend_s1, pend_d;
	logic               ovalid_q, ovalid_d;

	op_t                op_q, op_d;
	logic [KEY_W-1:0]   key_q, key_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [CW-1:0]      idx_s1, idx_s1_d;
	status_t            st_q, st_d;
	logic               fnd_q, fnd_d;
	logic [TAG_W-1:0]   rt_q, rt_d;
	logic [VAL_W-1:0]   rv_q, rv_d;

	status_t            ost_q;
	logic               ofnd_q;
	logic [CNT_O_W-1:0] ocnt_q;
	logic [TAG_W-1:0]   ort_q;
	logic [VAL_W-1:0]   orv_q;
	logic               oload;

	logic               re, we;
	logic [AW-1:0]      raddr, waddr;
	logic [KEY_W-1:0]   wdata, rdata;

	logic               match, more, pos_ok, has_room;
	logic [CW+POS_W-1:0] pos_ext, cnt_ext;
	logic [CW+CNT_O_W-1:0] cnt_wide;

	ots_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign match    = pend_s1 && (rdata == key_q);
	assign more     = idx_q < count_q;
	assign has_room = count_q < CW'(CAPACITY);
	assign pos_ext  = {{CW{1'b0}}, pos_q};
	assign cnt_ext  = {{POS_W{1'b0}}, count_q};
	assign pos_ok   = pos_ext < cnt_ext;
	assign cnt_wide = {{CNT_O_W{1'b0}}, count_q};
	assign oload    = (state_q == S_FIN) && (!ovalid_q || rsp.ready);

	// RAM port control
	always_comb begin
		re    = 1'b0;
		raddr = idx_q[AW-1:0];
		we    = 1'b0;
		waddr = idx_s1[AW-1:0];
		wdata = rdata;
		unique case (state_q)
			S_RD: begin
				re    = pos_ok;
				raddr = pos_ext[AW-1:0];
			end
			S_SCAN: begin
				re = !match && more;
				if (!match && !more && op_q == OP_ADD && has_room) begin
					we    = 1'b1;
					waddr = count_q[AW-1:0];
					wdata = key_q;
				end
			end
			S_SHIFT: begin
				re = more;
				we = pend_s1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		pend_d   = pend_s1;
		ovalid_d = ovalid_q && !rsp.ready;
		op_d     = op_q;
		key_d    = key_q;
		pos_d    = pos_q;
		idx_s1_d = idx_s1;
		st_d     = st_q;
		fnd_d    = fnd_q;
		rt_d     = rt_q;
		rv_d     = rv_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					op_d    = cmd.op;
					key_d   = {cmd.key_type, cmd.key_value};
					pos_d   = cmd.position;
					idx_d   = '0;
					pend_d  = 1'b0;
					st_d    = ST_OK;
					fnd_d   = 1'b0;
					rt_d    = '0;
					rv_d    = '0;
					state_d = (cmd.op == OP_READ) ? S_RD : S_SCAN;
				end
			end
			S_RD: begin
				if (pos_ok) begin
					state_d = S_RDW;
				end else begin
					st_d    = ST_RANGE;
					state_d = S_FIN;
				end
			end
			S_RDW: begin
				rt_d    = rdata[KEY_W-1:VAL_W];
				rv_d    = rdata[VAL_W-1:0];
				fnd_d   = 1'b1;
				state_d = S_FIN;
			end
			S_SCAN: begin
				priority if (match) begin
					fnd_d  = 1'b1;
					pend_d = 1'b0;
					if (op_q == OP_DEL) begin
						idx_d   = idx_s1 + CW'(1);
						state_d = S_SHIFT;
					end else begin
						if (op_q == OP_ADD) begin
							st_d = ST_DUP;
						end
						state_d = S_FIN;
					end
				end else if (more) begin
					pend_d   = 1'b1;
					idx_s1_d = idx_q;
					idx_d    = idx_q + CW'(1);
				end else begin
					pend_d  = 1'b0;
					state_d = S_FIN;
					if (op_q == OP_ADD) begin
						if (has_room) begin
							count_d = count_q + CW'(1);
						end else begin
							st_d = ST_FULL;
						end
					end else begin
						st_d = ST_MISS;
					end
				end
			end
			S_SHIFT: begin
				if (more) begin
					pend_d   = 1'b1;
					idx_s1_d = idx_q - CW'(1);
					idx_d    = idx_q + CW'(1);
				end else begin
					pend_d = 1'b0;
					if (!pend_s1) begin
						count_d = count_q - CW'(1);
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (oload) begin
					ovalid_d = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			pend_s1  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			pend_s1  <= pend_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		key_q  <= key_d;
		pos_q  <= pos_d;
		idx_s1 <= idx_s1_d;
		st_q   <= st_d;
		fnd_q  <= fnd_d;
		rt_q   <= rt_d;
		rv_q   <= rv_d;
		if (oload) begin
			ost_q  <= st_q;
			ofnd_q <= fnd_q;
			ocnt_q <= cnt_wide[CNT_O_W-1:0];
			ort_q  <= rt_q;
			orv_q  <= rv_q;
		end
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = ovalid_q;
	assign rsp.status      = ost_q;
	assign rsp.found       = ofnd_q;
	assign rsp.entry_count = ocnt_q;
	assign rsp.read_type   = ort_q;
	assign rsp.read_value  = orv_q;
endmodule

/* src/ots_checker.sv */
// ---------------------------------------------------------------------------
// ots_checker
// Port-level checks on the ordered typed set table, bound to the top level.
// ---------------------------------------------------------------------------
`include "ordered_typed_set_table_defines.svh"

module ots_checker #(
	parameter int CAPACITY = ots_pkg::DEF_CAPACITY
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [ots_pkg::STAT_W-1:0]  rsp_status,
	input logic                        rsp_found,
	input logic [ots_pkg::CNT_O_W-1:0] rsp_entry_count,
	input logic [ots_pkg::TAG_W-1:0]   rsp_read_type,
	input logic [ots_pkg::VAL_W-1:0]   rsp_read_value
);
	import ots_pkg::*;

	// one word in work at a time
	`OTS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)

	`OTS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_entry_count) && $stable(rsp_read_value))

	`OTS_ASSERT_NOW(a_found_vs_status, clk, arst_n, rsp_valid && (rsp_status != ST_OK), rsp_found == (rsp_status == ST_DUP))

	`OTS_ASSERT_NOW(a_read_zero, clk, arst_n, rsp_valid && !rsp_found, (rsp_read_type == '0) && (rsp_read_value == '0))

	`OTS_ASSERT_NOW(a_count_bound, clk, arst_n, rsp_valid && (CAPACITY < 128), 32'(rsp_entry_count) <= 32'(CAPACITY))
endmodule

bind ordered_typed_set_table ots_checker #(
	.CAPACITY (CAPACITY)
) u_ots_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found       (rsp.found),
	.rsp_entry_count (rsp.entry_count),
	.rsp_read_type   (rsp.read_type),
	.rsp_read_value  (rsp.read_value)
);
